>>> hdl/smf_pkg.sv
// Shared types and constants for the streaming substring search.
// No dependencies; imported by every other file of the block.
package smf_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 16;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int RESULT_W    = POS_W + 1;
    localparam int M_TDATA_W   = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PATTERN_LOW  = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_PATTERN_HIGH = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_PATTERN_LEN  = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_START_POS    = cfg_idx_t'(3);

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

>>> hdl/substring_first_match_top.sv
// Top level of the streaming first-match substring search: a chain of window
// cells, the match bookkeeping and the output skid stage. Depends on smf_pkg.
//
//  port group  | dir | payload
//  s_*         | in  | tdata[7:0] text byte, tlast end of text
//  m_*         | out | tdata[0] found, tdata[16:1] match position
//  cfg_*       | in  | cfg_index register, cfg_data value (always ready)
//
// One word per cycle while s_tready is high; the window compare across all cells
// completes in the cycle the byte is taken. The last word's result is registered.
// Reset: synchronous, active low; clears window, counters, config; pattern length to 1.
// Stalls: two result slots; s_tready falls only when both are occupied.
module substring_first_match_top #(
    parameter int PATTERN_MAX_BYTES = 16,
    parameter int TEXT_MAX_BYTES    = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [smf_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [smf_pkg::M_TDATA_W-1:0] m_tdata,   // [0] found, [16:1] match_position
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import smf_pkg::*;

    localparam int CNT_W = $clog2(TEXT_MAX_BYTES);
    localparam logic [CNT_W-1:0] LIMIT   = CNT_W'(TEXT_MAX_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX_BYTES);

    // configuration
    logic [CFG_DATA_W-1:0] pat_lo_reg, pat_hi_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [POS_W-1:0]      start_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= LEN_W'(1);
            start_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pat_lo_reg  <= cfg_data;
                CFG_PATTERN_HIGH: pat_hi_reg  <= cfg_data;
                CFG_PATTERN_LEN:  pat_len_reg <= cfg_data[LEN_W-1:0];
                CFG_START_POS:    start_reg   <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] len_c;

    always_comb begin
        priority if (pat_len_reg == '0) begin
            len_c = LEN_W'(1);
        end else if (pat_len_reg > LEN_MAX) begin
            len_c = LEN_MAX;
        end else begin
            len_c = pat_len_reg;
        end
    end

    logic [BYTE_W-1:0] pat_byte [PAT_BYTES];

    for (genvar k = 0; k < PAT_BYTES; k++) begin : g_pat
        if (k < 8) begin : g_lo
            assign pat_byte[k] = pat_lo_reg[k*BYTE_W +: BYTE_W];
        end else begin : g_hi
            assign pat_byte[k] = pat_hi_reg[(k-8)*BYTE_W +: BYTE_W];
        end
    end

    // cell chain
    logic       accept;
    logic       push_ready;
    cell_ctrl_t ctrl;

    assign s_tready   = push_ready;
    assign accept     = s_tvalid && s_tready;
    assign ctrl.shift = accept;
    assign ctrl.clear = accept && s_tlast;

    logic [BYTE_W-1:0]            win [PATTERN_MAX_BYTES];
    logic [PATTERN_MAX_BYTES-1:0] eq_vec;
    logic [PATTERN_MAX_BYTES-1:0] use_vec;

    for (genvar j = 0; j < PATTERN_MAX_BYTES; j++) begin : g_cell
        logic [BYTE_W-1:0]    d_in;
        logic [PAT_IDX_W-1:0] exp_idx;

        if (j == 0) begin : g_head
            assign d_in = s_tdata;
        end else begin : g_link
            assign d_in = win[j-1];
        end

        assign exp_idx    = PAT_IDX_W'(len_c - LEN_W'(j) - LEN_W'(1));
        assign use_vec[j] = LEN_W'(j) < len_c;

        smf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .d_in     (d_in),
            .expected (pat_byte[exp_idx]),
            .q        (win[j]),
            .eq       (eq_vec[j])
        );
    end

    logic hit_all;
    assign hit_all = &(eq_vec | ~use_vec);

    // match bookkeeping
    logic [CNT_W-1:0] seen_reg, seen_next, seen_upd;
    logic             match_reg, match_next, match_upd;
    logic [POS_W-1:0] first_reg, first_next, first_upd;
    logic [POS_W:0]   seen_plus1;
    logic [POS_W:0]   begin_w;

    assign seen_plus1 = {1'b0, POS_W'(seen_reg)} + (POS_W+1)'(1);
    assign begin_w    = seen_plus1 - (POS_W+1)'(len_c);

    always_comb begin
        seen_upd  = seen_reg;
        match_upd = match_reg;
        first_upd = first_reg;
        if (seen_reg < LIMIT) begin
            if (!match_reg && (seen_plus1 >= (POS_W+1)'(len_c))
                    && (begin_w >= {1'b0, start_reg}) && hit_all) begin
                match_upd = 1'b1;
                first_upd = begin_w[POS_W-1:0];
            end
            seen_upd = seen_reg + CNT_W'(1);
        end
        seen_next  = seen_reg;
        match_next = match_reg;
        first_next = first_reg;
        if (accept) begin
            if (s_tlast) begin
                seen_next  = '0;
                match_next = 1'b0;
                first_next = '0;
            end else begin
                seen_next  = seen_upd;
                match_next = match_upd;
                first_next = first_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            match_reg <= 1'b0;
            first_reg <= '0;
        end else begin
            seen_reg  <= seen_next;
            match_reg <= match_next;
            first_reg <= first_next;
        end
    end

    // result
    logic [RESULT_W-1:0] res_in, res_out;

    assign res_in = {(match_upd ? first_upd : POS_W'(0)), match_upd};

    smf_out_skid #(.W(RESULT_W)) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (ctrl.clear),
        .push_data  (res_in),
        .push_ready (push_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (res_out)
    );

    assign m_tdata = {(M_TDATA_W-RESULT_W)'(0), res_out};

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after last word");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (seen_reg == '0 && !match_reg))
        else $error("search state not cleared");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[POS_W:1] == '0))
        else $error("position set without match");

    a_match_behind_count: assert property (@(posedge aclk) disable iff (!aresetn)
        match_reg |-> (first_reg < POS_W'(seen_reg)))
        else $error("match position beyond bytes seen");
`endif

endmodule

>>> hdl/smf_cell.sv
// One window cell: holds a text byte, passes it to the next cell and compares
// the byte coming in against its expected pattern byte. Depends on smf_pkg.
module smf_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  smf_pkg::cell_ctrl_t       ctrl,
    input  logic [smf_pkg::BYTE_W-1:0] d_in,
    input  logic [smf_pkg::BYTE_W-1:0] expected,
    output logic [smf_pkg::BYTE_W-1:0] q,
    output logic                      eq
);
    import smf_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.clear) begin
            byte_next = '0;
        end else if (ctrl.shift) begin
            byte_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign q  = byte_reg;
    assign eq = (d_in == expected);

endmodule

>>> hdl/smf_out_skid.sv
// Two-entry output stage: output register plus skid register.
// Depends on smf_pkg.
module smf_out_skid #(
    parameter int W = 17
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    import smf_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] skid_data_reg, skid_data_next;
    logic         pop;

    assign pop = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

>>> tb/tb_substring_first_match_top.sv
// Self-checking bench for substring_first_match_top: streams texts, predicts each
// first-match report in step with accepted words, and checks the result stream.
// Depends on smf_pkg and the block's RTL; needs no files or arguments.
module tb_substring_first_match_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    localparam int unsigned SEEN_MAX = 65535;
    localparam cfg_idx_t CFG_NO_REG = cfg_idx_t'(8'hA7);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } text_word_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } match_report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // search configuration as the block should hold it
    logic [63:0]      pat_lo = '0;
    logic [63:0]      pat_hi = '0;
    logic [LEN_W-1:0] pat_len = LEN_W'(1);
    logic [POS_W-1:0] start_pos = '0;

    // predicted search state
    logic [BYTE_W-1:0] win [PAT_BYTES];
    int unsigned       seen = 0;
    bit                hit = 1'b0;
    logic [POS_W-1:0]  hit_at = '0;

    text_word_t    text_q[$];
    match_report_t report_q[$];

    int unsigned mismatches = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    logic        idle_on = 1'b1;
    logic        hold_go = 1'b0;
    logic        hold_taken = 1'b0;
    int unsigned hold_left = 0;

    substring_first_match_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] text_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [0] found, [16:1] match_position
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned eff_len();
        if (pat_len == 0) return 1;
        if (pat_len > PAT_BYTES) return PAT_BYTES;
        return pat_len;
    endfunction

    function automatic logic [BYTE_W-1:0] pat_byte(input int unsigned k);
        return (k < 8) ? pat_lo[k*8 +: 8] : pat_hi[(k-8)*8 +: 8];
    endfunction

    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned   n;
        int unsigned   from;
        bit            ok;
        match_report_t rep;
        n = eff_len();
        for (int i = PAT_BYTES - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (seen < SEEN_MAX) begin
            if (!hit && seen + 1 >= n) begin
                from = seen + 1 - n;
                ok = (from >= start_pos);
                for (int k = 0; k < n; k++)
                    if (win[n-1-k] != pat_byte(k)) ok = 1'b0;
                if (ok) begin
                    hit = 1'b1;
                    hit_at = from[POS_W-1:0];
                end
            end
            seen++;
        end
        if (last) begin
            rep.found = hit;
            rep.pos = hit ? hit_at : '0;
            report_q.push_back(rep);
            foreach (win[i]) win[i] = '0;
            seen = 0;
            hit = 1'b0;
            hit_at = '0;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%t %s", $realtime, what);
    endtask

    // text driver
    always @(posedge aclk) begin
        text_word_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_on && text_q.size() != 0 && $urandom_range(0, 11) == 0) begin
                    tx_gap = $urandom_range(0, 15);
                    s_tvalid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    nxt = text_q.pop_front();
                    s_tdata <= nxt.data;
                    s_tlast <= nxt.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_go && !hold_taken) begin
            hold_left <= 300;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        match_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (report_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected report: found=%0d pos=%0d",
                                            m_tdata[0], m_tdata[16:1]));
                end else begin
                    want = report_q.pop_front();
                    if (m_tdata[0] !== want.found)
                        note_mismatch($sformatf("found: expected %0d, got %0d",
                                                want.found, m_tdata[0]));
                    if (m_tdata[16:1] !== want.pos)
                        note_mismatch($sformatf("match_position: expected %0d, got %0d",
                                                want.pos, m_tdata[16:1]));
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                rx_gap = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PATTERN_LOW:  pat_lo = val;
            CFG_PATTERN_HIGH: pat_hi = val;
            CFG_PATTERN_LEN:  pat_len = val[LEN_W-1:0];
            CFG_START_POS:    start_pos = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_search(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] lenv, input logic [63:0] startv);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LEN, lenv);
        write_reg(CFG_START_POS, startv);
    endtask

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic last);
        text_word_t w;
        w.data = b;
        w.last = last;
        text_q.push_back(w);
    endtask

    task automatic drain();
        do @(negedge aclk); while (text_q.size() != 0 || s_tvalid || report_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // mostly pattern-flavored text with planted copies, some pure noise
    task automatic gen_text(input int unsigned len);
        logic [BYTE_W-1:0] t[$];
        int unsigned       n;
        int unsigned       p;
        bit                noise;
        n = eff_len();
        noise = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
            t.push_back((noise || $urandom_range(0, 3) == 0) ? 8'($urandom)
                                                             : pat_byte($urandom_range(0, n-1)));
        if (!noise && len >= n) begin
            repeat ($urandom_range(0, 2)) begin
                p = $urandom_range(0, len - n);
                for (int k = 0; k < n; k++) t[p+k] = pat_byte(k);
                if ($urandom_range(0, 3) == 0) t[p + $urandom_range(0, n-1)] ^= 8'($urandom_range(1, 255));
            end
        end
        foreach (t[i]) push_word(t[i], i == len - 1);
    endtask

    task automatic random_phase(input int unsigned words);
        logic [63:0]       lo;
        logic [63:0]       hi;
        logic [63:0]       lenv;
        logic [63:0]       startv;
        logic [BYTE_W-1:0] a0;
        logic [BYTE_W-1:0] a1;
        logic [BYTE_W-1:0] b;
        int unsigned       sent;
        int unsigned       r;
        bit                narrow;
        narrow = ($urandom_range(0, 2) != 0);
        a0 = 8'($urandom);
        a1 = 8'($urandom);
        for (int k = 0; k < PAT_BYTES; k++) begin
            b = narrow ? ($urandom_range(0, 1) ? a0 : a1) : 8'($urandom);
            if (k < 8) lo[k*8 +: 8] = b;
            else hi[(k-8)*8 +: 8] = b;
        end
        lenv = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        r = $urandom_range(0, 9);
        if (r < 6) lenv[4:0] = 5'($urandom_range(1, 4));
        else if (r < 9) lenv[4:0] = 5'($urandom_range(5, 16));
        else lenv[4:0] = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
        startv = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        r = $urandom_range(0, 9);
        if (r < 3) startv[15:0] = 16'($urandom_range(0, 30));
        else if (r == 3) startv[15:0] = 16'($urandom);
        else startv[15:0] = '0;
        set_search(lo, hi, lenv, startv);
        sent = 0;
        while (sent < words) begin
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            gen_text(r);
            sent += r;
        end
    endtask

    initial begin
        foreach (win[i]) win[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: one zero byte
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);
        push_word(8'hFF, 1'b1);
        drain();

        // full 16-byte pattern at index 0
        set_search(64'hFF00_A55A_0102_80FF, 64'h0000_FFFF_1234_7E81, 64'd16, 64'd0);
        for (int k = 0; k < PAT_BYTES; k++) push_word(pat_byte(k), k == PAT_BYTES - 1);
        drain();

        // zero length acts as one
        set_search(64'h0000_0000_0000_00FF, 64'd0, 64'd0, 64'd0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b1);
        drain();

        // oversized length, start past the text, unknown register
        write_reg(CFG_PATTERN_LEN, '1);
        write_reg(CFG_START_POS, '1);
        write_reg(CFG_NO_REG, '1);
        push_word(8'h00, 1'b1);
        drain();

        // back-pressure: receiver stalls while one-word texts keep coming
        set_search({$urandom, $urandom}, {$urandom, $urandom}, 64'd1, 64'd0);
        @(posedge aclk);
        hold_go <= 1'b1;
        repeat (60) gen_text(1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                @(posedge aclk);
                idle_on <= 1'b0;
            end
            random_phase(140);
            drain();
        end

        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb_substring_first_match_top: clean");
        end else begin
            $display("tb_substring_first_match_top: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_substring_first_match_top: errors");
        $finish;
    end

endmodule
